### hw/rtl/b2da_pkg.sv
package b2da_pkg;

  localparam int ValueWidth = 32;
  localparam int NumDigits  = 10;
  localparam int BcdWidth   = 4 * NumDigits;
  localparam int CharWidth  = 6;
  localparam int StepWidth  = $clog2(ValueWidth);
  localparam int IdxWidth   = $clog2(NumDigits);

  localparam logic [CharWidth-1:0] AsciiZero = CharWidth'(48);
  localparam logic [3:0]           AddLimit  = 4'd5;
  localparam logic [3:0]           AddFix    = 4'd3;

  typedef logic [BcdWidth-1:0]   bcd_t;
  typedef logic [ValueWidth-1:0] value_t;

endpackage

### hw/rtl/b2da_dabble.sv
module b2da_dabble
  import b2da_pkg::*;
(
  input  bcd_t bcd,
  input  logic bit_in,
  output bcd_t bcd_next
);

  bcd_t fixed;

  // add three to every digit of five or more, then shift in one bit
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd[4*i +: 4] >= AddLimit) begin
        fixed[4*i +: 4] = bcd[4*i +: 4] + AddFix;
      end else begin
        fixed[4*i +: 4] = bcd[4*i +: 4];
      end
    end
    bcd_next = {fixed[BcdWidth-2:0], bit_in};
  end

endmodule

### hw/rtl/binary_to_decimal_ascii.sv
// channel   direction  handshake            ports
// ------    ---------  -------------------  ---------------------------------
// input     in         start & !busy        value
// result    out        strobe (one cycle)   digit_char, last
//
// an accepted value first runs the shift-add-3 steps on the shared digit unit, then the
// digits are swept, with a strobe on digits past the leading zeros and on the units digit.
// busy drops with the last character, so a new value can be taken as soon as it is shown.
// rst is synchronous and clears the sequencer and the strobe.
// the receiver cannot stall; every character is shown for one cycle only.
module binary_to_decimal_ascii
  import b2da_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [31:0]          value,
  output logic                 busy,
  output logic                 strobe,
  output logic [CharWidth-1:0] digit_char,
  output logic                 last
);

  typedef enum logic [1:0] {
    IDLE,
    CONV,
    EMIT
  } state_t;

  state_t                state;
  value_t                bin;
  bcd_t                  bcd;
  bcd_t                  bcd_next;
  logic [StepWidth-1:0]  step;
  logic [IdxWidth-1:0]   idx;
  logic                  seen;
  logic [3:0]            top_digit;

  b2da_dabble u_dabble (
    .bcd      (bcd),
    .bit_in   (bin[ValueWidth-1]),
    .bcd_next (bcd_next)
  );

  assign top_digit = bcd[BcdWidth-1 -: 4];
  assign busy      = (state != IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      seen   <= 1'b0;
      strobe <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          strobe <= 1'b0;
          if (start) begin
            bin   <= value;
            bcd   <= '0;
            step  <= '0;
            state <= CONV;
          end
        end
        CONV: begin
          strobe <= 1'b0;
          bcd    <= bcd_next;
          bin    <= {bin[ValueWidth-2:0], 1'b0};
          step   <= step + 1'b1;
          if (step == StepWidth'(ValueWidth - 1)) begin
            idx   <= IdxWidth'(NumDigits - 1);
            seen  <= 1'b0;
            state <= EMIT;
          end
        end
        EMIT: begin
          // leading zeros are dropped, but the units digit always goes out
          if (top_digit != 4'd0 || seen || idx == '0) begin
            strobe     <= 1'b1;
            digit_char <= AsciiZero + {{(CharWidth-4){1'b0}}, top_digit};
            last       <= (idx == '0);
            seen       <= 1'b1;
          end else begin
            strobe <= 1'b0;
          end
          bcd <= {bcd[BcdWidth-5:0], 4'd0};
          idx <= idx - 1'b1;
          if (idx == '0) begin
            state <= IDLE;
          end
        end
        default: begin
          strobe <= 1'b0;
          state  <= IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/b2da_checker.sv
module b2da_checker
  import b2da_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 strobe,
  input logic [CharWidth-1:0] digit_char,
  input logic                 last
);

  // a word only leaves while a conversion is running
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("word without a running conversion");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted value did not raise busy");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (digit_char >= CharWidth'(48) && digit_char <= CharWidth'(57)))
    else $error("character is not a decimal digit");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy)
    else $error("busy still high after the last word");

  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .strobe     (strobe),
  .digit_char (digit_char),
  .last       (last)
);
